>>> sv/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned MaxWidth = 32;
  localparam int unsigned MinWidth = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WidthCfgW = 6;
  localparam int unsigned ShiftW   = $clog2(MaxWidth);
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [WidthCfgW-1:0] ResetWidth  = WidthCfgW'(32);
  localparam logic [CrcW-1:0]      ResetPoly   = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0]      ResetInit   = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]      ResetXorOut = 32'hFFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCrcWidth   = 3'd0,
    CfgPolynomial = 3'd1,
    CfgInitValue  = 3'd2,
    CfgFinalXor   = 3'd3,
    CfgReflectIn  = 3'd4,
    CfgReflectOut = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WidthCfgW-1:0] crc_width;
    logic [CrcW-1:0]      polynomial;
    logic [CrcW-1:0]      initial_value;
    logic [CrcW-1:0]      final_xor;
    logic                 reflect_input;
    logic                 reflect_output;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/configurable_crc_checker_unit.sv
`default_nettype none

// CRC checker for one message byte per item under a configurable model of width 8 to 32
// bits, with polynomial, initial value, final XOR and input and output reflection set
// through the register write port (writes are meant for an idle block). A new item is
// taken every cycle: the byte update is one pass of logic between the input register and
// the running CRC register, so throughput is one byte per clock. The item marked by tlast
// is registered into the result register as one result item, carrying the finished CRC
// and a flag that tells whether it equals the expected value sent with that last byte.
// The input stalls only while a final item waits behind a result that is not yet taken.
module configurable_crc_checker_unit
  import ccc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CrcW-1:0]      cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: data_byte[7:0], check_crc[39:8].
  input  logic [ByteW+CrcW-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: crc_value[31:0].
  output logic [CrcW-1:0]      m_axis_tdata,
  // Fields from bit 0: crc_matches[0].
  output logic                 m_axis_tuser
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_width      <= ResetWidth;
      cfg_q.polynomial     <= ResetPoly;
      cfg_q.initial_value  <= ResetInit;
      cfg_q.final_xor      <= ResetXorOut;
      cfg_q.reflect_input  <= 1'b1;
      cfg_q.reflect_output <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCrcWidth:   cfg_q.crc_width      <= cfg_data_i[WidthCfgW-1:0];
        CfgPolynomial: cfg_q.polynomial     <= cfg_data_i;
        CfgInitValue:  cfg_q.initial_value  <= cfg_data_i;
        CfgFinalXor:   cfg_q.final_xor      <= cfg_data_i;
        CfgReflectIn:  cfg_q.reflect_input  <= cfg_data_i[0];
        CfgReflectOut: cfg_q.reflect_output <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic [CrcW-1:0]  in_exp_q;
  logic             in_adv;

  logic [CrcW-1:0]  crc_q, crc_d;
  logic             mid_q;
  logic [CrcW-1:0]  crc_final;

  logic             out_valid_q;
  logic [CrcW-1:0]  out_crc_q;
  logic             out_match_q;
  logic             out_load;

  // A non-final item always moves on; a final one needs the result register free.
  assign out_load      = in_valid_q && in_last_q && (!out_valid_q || m_axis_tready);
  assign in_adv        = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata[ByteW-1:0];
      in_exp_q  <= s_axis_tdata[ByteW+CrcW-1:ByteW];
      in_last_q <= s_axis_tlast;
    end
  end

  ccc_core u_core (
    .cfg_i         (cfg_q),
    .mid_message_i (mid_q),
    .running_crc_i (crc_q),
    .data_byte_i   (in_byte_q),
    .crc_next_o    (crc_d),
    .crc_final_o   (crc_final)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      mid_q <= 1'b0;
    end else if (in_adv) begin
      crc_q <= crc_d;
      mid_q <= !in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_crc_q   <= crc_final;
      out_match_q <= (crc_final == in_exp_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;
  assign m_axis_tuser  = out_match_q;

`ifndef ASSERT_OFF
  a_mid_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(mid_q) |-> $past(in_adv && in_last_q))
    else $error("message state ended without a final item");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_last_q))
    else $error("result appeared without a final item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

>>> sv/ccc_core.sv
`default_nettype none

module ccc_core
  import ccc_pkg::*;
(
  input  cfg_t            cfg_i,
  input  logic            mid_message_i,
  input  logic [CrcW-1:0] running_crc_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic [CrcW-1:0] crc_next_o,
  output logic [CrcW-1:0] crc_final_o
);

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] rev32(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

  logic [WidthCfgW-1:0] width;
  logic [ShiftW-1:0]    shift;
  logic [CrcW-1:0]      mask;
  logic [CrcW-1:0]      poly_al;
  logic [CrcW-1:0]      reg_al;
  logic [CrcW-1:0]      start;
  logic [ByteW-1:0]     byte_in;
  logic [CrcW-1:0]      finished;

  // The register is kept left-aligned so that its top bit always sits at bit 31.
  always_comb begin
    if (cfg_i.crc_width < WidthCfgW'(MinWidth)) begin
      width = WidthCfgW'(MinWidth);
    end else if (cfg_i.crc_width > WidthCfgW'(MaxWidth)) begin
      width = WidthCfgW'(MaxWidth);
    end else begin
      width = cfg_i.crc_width;
    end
    shift   = ShiftW'(WidthCfgW'(MaxWidth) - width);
    mask    = {CrcW{1'b1}} >> shift;
    poly_al = cfg_i.polynomial << shift;
    start   = mid_message_i ? running_crc_i : cfg_i.initial_value;
    byte_in = cfg_i.reflect_input ? rev8(data_byte_i) : data_byte_i;
    reg_al  = start << shift;
    reg_al[CrcW-1 -: ByteW] = reg_al[CrcW-1 -: ByteW] ^ byte_in;
    for (int b = 0; b < ByteW; b++) begin
      if (reg_al[CrcW-1]) begin
        reg_al = (reg_al << 1) ^ poly_al;
      end else begin
        reg_al = reg_al << 1;
      end
    end
    crc_next_o  = reg_al >> shift;
    finished    = cfg_i.reflect_output ? rev32(reg_al) : crc_next_o;
    crc_final_o = (finished ^ cfg_i.final_xor) & mask;
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
  import ccc_pkg::*;

  typedef struct packed {
    logic [CrcW-1:0] value;
    logic            match_ok;
  } crc_result_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic [CrcW-1:0]  expected;
    logic             pinned;
    logic [CrcW-1:0]  crc;
    logic             match_ok;
  } dir_row_t;

  localparam int unsigned NumFixed    = 10;
  localparam int unsigned NumPhases   = 16;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PressurePhase = 1;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  cfg_idx_e              cfg_index_i = CfgCrcWidth;
  logic [CrcW-1:0]       cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteW+CrcW-1:0] s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CrcW-1:0]       m_axis_tdata;
  logic                  m_axis_tuser;

  configurable_crc_checker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  cfg_t            crc_cfg;
  logic [CrcW-1:0] crc_reg;
  logic            in_message;
  crc_result_t     pending_crcs[$];
  int unsigned     error_count;
  bit              tx_gaps;
  bit              rx_gaps;
  int unsigned     hold_left;
  int unsigned     stall_left;

  dir_row_t directed_rows[22] = '{
    '{8'h31, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h32, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h33, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h34, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h35, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h36, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h37, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h38, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h39, 1'b1, 32'hCBF4_3926, 1'b1, 32'hCBF4_3926, 1'b1},
    '{8'h00, 1'b1, 32'hD202_EF8D, 1'b1, 32'hD202_EF8D, 1'b1},
    '{8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hD202_EF8D, 1'b0},
    '{8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{8'hFF, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h31, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h32, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h33, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h34, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h35, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h36, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h37, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h38, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{8'h39, 1'b1, 32'h0000_0000, 1'b1, 32'hCBF4_3926, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int unsigned crc_bits();
    int unsigned w;
    w = 32'(crc_cfg.crc_width);
    if (w < MinWidth) w = MinWidth;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic logic [CrcW-1:0] crc_mask(int unsigned w);
    return (w >= CrcW) ? '1 : ((32'h1 << w) - 32'h1);
  endfunction

  function automatic logic [CrcW-1:0] crc_advance(logic [CrcW-1:0] start,
                                                  logic [ByteW-1:0] data);
    int unsigned      w;
    logic [CrcW-1:0]  m;
    logic [CrcW-1:0]  poly;
    logic [CrcW-1:0]  r;
    logic [ByteW-1:0] b;
    w = crc_bits();
    m = crc_mask(w);
    poly = crc_cfg.polynomial & m;
    r = start & m;
    b = data;
    if (crc_cfg.reflect_input) begin
      for (int i = 0; i < ByteW; i++) b[ByteW-1-i] = data[i];
    end
    r = r ^ (32'(b) << (w - ByteW));
    for (int k = 0; k < 8; k++) begin
      if (r[w-1]) begin
        r = ((r << 1) ^ poly) & m;
      end else begin
        r = (r << 1) & m;
      end
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] crc_finish(logic [CrcW-1:0] r);
    int unsigned     w;
    logic [CrcW-1:0] o;
    w = crc_bits();
    o = r;
    if (crc_cfg.reflect_output) begin
      o = '0;
      for (int i = 0; i < CrcW; i++) begin
        if (i < w) o[w-1-i] = r[i];
      end
    end
    return (o ^ crc_cfg.final_xor) & crc_mask(w);
  endfunction

  function automatic logic [CrcW-1:0] crc_if_last(logic [ByteW-1:0] data);
    return crc_finish(crc_advance(in_message ? crc_reg : crc_cfg.initial_value, data));
  endfunction

  function automatic cfg_t make_setting(int unsigned w, logic [CrcW-1:0] poly,
                                        logic [CrcW-1:0] init, logic [CrcW-1:0] xo,
                                        logic ri, logic ro);
    cfg_t s;
    s.crc_width      = w[WidthCfgW-1:0];
    s.polynomial     = poly;
    s.initial_value  = init;
    s.final_xor      = xo;
    s.reflect_input  = ri;
    s.reflect_output = ro;
    return s;
  endfunction

  // Widths 0, 7, 33 and 63 lie outside the legal range and must clamp.
  function automatic cfg_t phase_setting(int unsigned p);
    int unsigned w;
    case (p)
      0: return make_setting(8, 32'h07, 32'h0, 32'h0, 1'b0, 1'b0);
      1: return make_setting(16, 32'h1021, 32'hFFFF, 32'h0, 1'b0, 1'b0);
      2: return make_setting(0, $urandom(), $urandom(), $urandom(), 1'b1, 1'b0);
      3: return make_setting(7, $urandom(), $urandom(), $urandom(), 1'b0, 1'b1);
      4: return make_setting(33, $urandom(), $urandom(), $urandom(), 1'b1, 1'b1);
      5: return make_setting(63, $urandom(), $urandom(), $urandom(), 1'b0, 1'b0);
      6: return make_setting(32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0);
      7: return make_setting(32, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
      8: return make_setting(31, $urandom(), $urandom(), $urandom(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      9: return make_setting(9, $urandom(), $urandom(), $urandom(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      default: begin
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(8, 32);
        return make_setting(w, $urandom(), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CrcW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgCrcWidth:   crc_cfg.crc_width = value[WidthCfgW-1:0];
      CfgPolynomial: crc_cfg.polynomial = value;
      CfgInitValue:  crc_cfg.initial_value = value;
      CfgFinalXor:   crc_cfg.final_xor = value;
      CfgReflectIn:  crc_cfg.reflect_input = value[0];
      CfgReflectOut: crc_cfg.reflect_output = value[0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic apply_setting(cfg_t s);
    write_reg(CfgCrcWidth, ($urandom() & ~32'h3F) | 32'(s.crc_width));
    write_reg(CfgPolynomial, s.polynomial);
    write_reg(CfgInitValue, s.initial_value);
    write_reg(CfgFinalXor, s.final_xor);
    write_reg(CfgReflectIn, ($urandom() & ~32'h1) | 32'(s.reflect_input));
    write_reg(CfgReflectOut, ($urandom() & ~32'h1) | 32'(s.reflect_output));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(logic [ByteW-1:0] data, logic last, logic [CrcW-1:0] expected,
                           logic pinned, crc_result_t pinned_res);
    crc_result_t     want;
    logic [CrcW-1:0] next_reg;
    if (tx_gaps && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {expected, data};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    next_reg = crc_advance(in_message ? crc_reg : crc_cfg.initial_value, data);
    crc_reg = next_reg;
    in_message = !last;
    if (last) begin
      want.value = crc_finish(next_reg);
      want.match_ok = (want.value == expected);
      pending_crcs.push_back(pinned ? pinned_res : want);
    end
  endtask

  task automatic send_message(int unsigned len, output int unsigned sent);
    logic [ByteW-1:0] data;
    logic [CrcW-1:0]  expected;
    logic [CrcW-1:0]  crc;
    for (int unsigned i = 0; i < len; i++) begin
      data = ByteW'($urandom());
      expected = $urandom();
      if (i == len - 1) begin
        crc = crc_if_last(data);
        case ($urandom_range(0, 3))
          0, 1: expected = crc;
          2: expected = crc ^ (32'h1 << $urandom_range(0, 31));
          default: ;
        endcase
      end
      send_byte(data, i == len - 1, expected, 1'b0, '0);
    end
    sent = len;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_crcs.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (rx_gaps && $urandom_range(0, 99) < 10) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    crc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_crcs.size() == 0) begin
        $error("unexpected result item: crc_value %h crc_matches %b",
               m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_crcs.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("crc_value: expected %h, got %h", want.value, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== want.match_ok) begin
          $error("crc_matches: expected %b, got %b", want.match_ok, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    crc_result_t pinned_res;
    int unsigned phase_count;
    int unsigned sent;
    int unsigned len;
    crc_cfg = make_setting(32'(ResetWidth), ResetPoly, ResetInit, ResetXorOut, 1'b1, 1'b1);
    crc_reg = '0;
    in_message = 1'b0;
    error_count = 0;
    hold_left = 0;
    stall_left = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      pinned_res.value = directed_rows[i].crc;
      pinned_res.match_ok = directed_rows[i].match_ok;
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].expected,
                directed_rows[i].pinned, pinned_res);
    end
    settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      apply_setting(phase_setting(p));
      tx_gaps = (p < NumPhases - 2) && ($urandom_range(0, 3) != 0);
      rx_gaps = (p < NumPhases - 2) && ($urandom_range(0, 3) != 0);
      if (p == PressurePhase) begin
        tx_gaps = 1'b0;
        hold_left = HoldCycles;
      end
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
          6, 7, 8: len = $urandom_range(5, 16);
          default: len = $urandom_range(17, 64);
        endcase
        if (p == PressurePhase) len = 1;
        send_message(len, sent);
        phase_count += sent;
      end
      // Leave a message open so the next setting lands mid-message.
      if (p < NumPhases - 1 && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(ByteW'($urandom()), 1'b0, $urandom(), 1'b0, '0);
        end
      end
      settle();
    end

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
